// ----- hw/rtl/srts_pkg.sv -----
// Shared types and constants for the shortest-remaining-time scheduler.
// Depends on nothing; every other file of the block refers to it by scoped names.
package srts_pkg;

    // Table size and derived widths.
    localparam int MAX_TASKS = 64;
    localparam int IDX_W     = $clog2(MAX_TASKS);
    localparam int CNT_W     = $clog2(MAX_TASKS + 1);

    // Fixed field widths.
    localparam int FIELD_W = 16;
    localparam int TIME_W  = 24;
    localparam int PID_W   = 7;

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    // Operation codes of an input beat.
    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_LOAD  = 2'd1,
        OP_TICK  = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    // Best candidate so far, handed from cell to cell during a scan.
    typedef struct packed {
        logic               found;
        logic [IDX_W-1:0]   idx;
        logic [FIELD_W-1:0] rem;
        logic [FIELD_W-1:0] arr;
        logic [FIELD_W-1:0] bur;
    } token_t;

    // Commands and shared state broadcast from the controller to every cell.
    typedef struct packed {
        logic               load;
        logic [FIELD_W-1:0] arr;
        logic [FIELD_W-1:0] bur;
        logic               run;
        logic [IDX_W-1:0]   run_idx;
        logic [CNT_W-1:0]   task_count;
        logic [TIME_W-1:0]  now;
    } cell_cmd_t;

endpackage

// ----- hw/rtl/srts_cell.sv -----
// One table entry of the scheduler plus its stage of the candidate chain.
// Depends on srts_pkg.
module srts_cell (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [srts_pkg::IDX_W-1:0] cell_index,
    input  srts_pkg::cell_cmd_t       cmd,
    input  logic                      tok_in_valid,
    input  srts_pkg::token_t          tok_in,
    output logic                      tok_out_valid,
    output srts_pkg::token_t          tok_out
);

    logic [srts_pkg::FIELD_W-1:0] arr_reg;
    logic [srts_pkg::FIELD_W-1:0] bur_reg;
    logic [srts_pkg::FIELD_W-1:0] rem_reg;
    logic                         done_reg;
    logic                         tok_valid_reg;
    srts_pkg::token_t             tok_reg;
    srts_pkg::token_t             tok_next;

    logic occupied;
    logic eligible;
    logic take;
    logic load_hit;
    logic run_hit;

    // The entry counts only below the fill count; it competes once it has arrived and while it is not yet done.
    assign occupied = srts_pkg::CNT_W'(cell_index) < cmd.task_count;
    assign eligible = occupied && !done_reg
                      && ({{(srts_pkg::TIME_W - srts_pkg::FIELD_W){1'b0}}, arr_reg} <= cmd.now);
    assign take     = eligible && (!tok_in.found || (rem_reg < tok_in.rem));

    assign load_hit = cmd.load && (srts_pkg::CNT_W'(cell_index) == cmd.task_count);
    assign run_hit  = cmd.run && (cmd.run_idx == cell_index);

    // Replace the incoming candidate with this entry when it is strictly better.
    always_comb
    begin
        tok_next = tok_in;
        if (take)
        begin
            tok_next.found = 1'b1;
            tok_next.idx   = cell_index;
            tok_next.rem   = rem_reg;
            tok_next.arr   = arr_reg;
            tok_next.bur   = bur_reg;
        end
    end

    // Entry storage: written by a load, decremented when this entry runs.
    always_ff @(posedge clk)
    begin
        if (load_hit)
        begin
            arr_reg  <= cmd.arr;
            bur_reg  <= cmd.bur;
            rem_reg  <= cmd.bur;
            done_reg <= (cmd.bur == '0);
        end
        else if (run_hit)
        begin
            rem_reg <= rem_reg - srts_pkg::FIELD_W'(1);
            if (rem_reg == srts_pkg::FIELD_W'(1))
            begin
                done_reg <= 1'b1;
            end
        end
    end

    // Chain stage: the valid bit is control, the candidate is payload.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_valid_reg <= 1'b0;
        end
        else
        begin
            tok_valid_reg <= tok_in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        tok_reg <= tok_next;
    end

    assign tok_out_valid = tok_valid_reg;
    assign tok_out       = tok_reg;

endmodule

// ----- hw/rtl/srts_chain.sv -----
// Row of scheduler cells; a candidate beat enters the first cell and walks to the last.
// Depends on srts_pkg and srts_cell.
module srts_chain (
    input  logic                clk,
    input  logic                rst_n,
    input  srts_pkg::cell_cmd_t cmd,
    input  logic                start,
    output logic                best_valid,
    output srts_pkg::token_t    best
);

    logic             link_valid [srts_pkg::MAX_TASKS+1];
    srts_pkg::token_t link_tok   [srts_pkg::MAX_TASKS+1];

    // An empty candidate enters the first cell when a scan starts.
    assign link_valid[0] = start;
    assign link_tok[0]   = '0;

    for (genvar g = 0; g < srts_pkg::MAX_TASKS; g++)
    begin : g_cell
        srts_cell u_cell (
            .clk           (clk),
            .rst_n         (rst_n),
            .cell_index    (srts_pkg::IDX_W'(g)),
            .cmd           (cmd),
            .tok_in_valid  (link_valid[g]),
            .tok_in        (link_tok[g]),
            .tok_out_valid (link_valid[g+1]),
            .tok_out       (link_tok[g+1])
        );
    end

    assign best_valid = link_valid[srts_pkg::MAX_TASKS];
    assign best       = link_tok[srts_pkg::MAX_TASKS];

endmodule

// ----- hw/rtl/shortest_remaining_time_scheduler.sv -----
// Top level of the shortest-remaining-time scheduler: controller, counters and result register.
// Depends on srts_pkg and srts_chain.
//
// Usage:
//   Input channel (item_valid/item_ready) carries operation, task_arrival and task_burst.
//   A clear beat empties the task table and zeroes time, a load beat appends a task,
//   a tick beat runs the eligible task with the least remaining time for one unit.
//   Output channel (result_valid/result_ready) returns exactly one result beat per item.
//   Path: clear, load, unused codes and ticks with nothing left to do go from
//   acceptance through S_POST into the output register. A working tick passes a
//   candidate down the row of MAX_TASKS cells, one cell per cycle, then updates the
//   winner in S_APPLY and hands its result on through S_POST.
//   Items: one at a time; a new beat is taken only once the controller is back in
//   S_IDLE, after the previous result has moved into the output register.
//   Stall: a finished result waits in the output register; the next item is still
//   accepted and worked on, then holds in the controller until that register frees.
//   Reset: task count, finished count and time are zero; table entries are undefined
//   until loaded and need no clearing pass.
module shortest_remaining_time_scheduler (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_ready,
    input  logic [1:0]                    operation,
    input  logic [srts_pkg::FIELD_W-1:0]  task_arrival,
    input  logic [srts_pkg::FIELD_W-1:0]  task_burst,
    output logic                          result_valid,
    input  logic                          result_ready,
    output logic                          ran,
    output logic [srts_pkg::PID_W-1:0]    process_id,
    output logic                          finished,
    output logic [srts_pkg::TIME_W-1:0]   turnaround,
    output logic [srts_pkg::TIME_W-1:0]   waiting,
    output logic                          all_done,
    output logic [srts_pkg::TIME_W-1:0]   now_time,
    output logic                          load_rejected
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_APPLY,
        S_POST
    } state_t;

    state_t                        state_reg,     state_next;
    logic [srts_pkg::CNT_W-1:0]    task_cnt_reg,  task_cnt_next;
    logic [srts_pkg::CNT_W-1:0]    fin_cnt_reg,   fin_cnt_next;
    logic [srts_pkg::TIME_W-1:0]   clock_reg,     clock_next;

    // Per-item result fields gathered before the output register.
    logic                          res_ran_reg,   res_ran_next;
    logic [srts_pkg::PID_W-1:0]    res_pid_reg,   res_pid_next;
    logic                          res_fin_reg,   res_fin_next;
    logic [srts_pkg::TIME_W-1:0]   res_tat_reg,   res_tat_next;
    logic [srts_pkg::FIELD_W-1:0]  res_bur_reg,   res_bur_next;
    logic                          res_rej_reg,   res_rej_next;

    // Output register.
    logic                          out_valid_reg, out_valid_next;
    logic                          out_ran_reg,   out_ran_next;
    logic [srts_pkg::PID_W-1:0]    out_pid_reg,   out_pid_next;
    logic                          out_fin_reg,   out_fin_next;
    logic [srts_pkg::TIME_W-1:0]   out_tat_reg,   out_tat_next;
    logic [srts_pkg::TIME_W-1:0]   out_wt_reg,    out_wt_next;
    logic                          out_done_reg,  out_done_next;
    logic [srts_pkg::TIME_W-1:0]   out_now_reg,   out_now_next;
    logic                          out_rej_reg,   out_rej_next;

    srts_pkg::cell_cmd_t           cmd;
    logic                          scan_start;
    logic                          best_valid;
    srts_pkg::token_t              best;

    logic                          accept;
    logic                          out_free;
    logic [srts_pkg::TIME_W-1:0]   clock_inc;
    logic [srts_pkg::TIME_W-1:0]   bur_wide;
    srts_pkg::op_t                 op;

    assign op         = srts_pkg::op_t'(operation);
    assign item_ready = (state_reg == S_IDLE);
    assign accept     = item_valid && item_ready;
    assign out_free   = !out_valid_reg || result_ready;
    assign clock_inc  = (clock_reg == srts_pkg::TIME_MAX) ? clock_reg
                                                          : clock_reg + srts_pkg::TIME_W'(1);
    assign bur_wide   = srts_pkg::TIME_W'(res_bur_reg);

    srts_chain u_chain (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .start      (scan_start),
        .best_valid (best_valid),
        .best       (best)
    );

    // Controller: next state, counters, cell commands and result fields.
    always_comb
    begin
        state_next     = state_reg;
        task_cnt_next  = task_cnt_reg;
        fin_cnt_next   = fin_cnt_reg;
        clock_next     = clock_reg;
        res_ran_next   = res_ran_reg;
        res_pid_next   = res_pid_reg;
        res_fin_next   = res_fin_reg;
        res_tat_next   = res_tat_reg;
        res_bur_next   = res_bur_reg;
        res_rej_next   = res_rej_reg;
        out_valid_next = out_valid_reg && !result_ready;
        out_ran_next   = out_ran_reg;
        out_pid_next   = out_pid_reg;
        out_fin_next   = out_fin_reg;
        out_tat_next   = out_tat_reg;
        out_wt_next    = out_wt_reg;
        out_done_next  = out_done_reg;
        out_now_next   = out_now_reg;
        out_rej_next   = out_rej_reg;
        scan_start     = 1'b0;

        cmd            = '0;
        cmd.arr        = task_arrival;
        cmd.bur        = task_burst;
        cmd.run_idx    = best.idx;
        cmd.task_count = task_cnt_reg;
        cmd.now        = clock_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res_ran_next = 1'b0;
                    res_pid_next = '0;
                    res_fin_next = 1'b0;
                    res_tat_next = '0;
                    res_bur_next = '0;
                    res_rej_next = 1'b0;
                    state_next   = S_POST;
                    case (op)
                        srts_pkg::OP_CLEAR:
                        begin
                            task_cnt_next = '0;
                            fin_cnt_next  = '0;
                            clock_next    = '0;
                        end
                        srts_pkg::OP_LOAD:
                        begin
                            if (task_cnt_reg < srts_pkg::CNT_W'(srts_pkg::MAX_TASKS))
                            begin
                                cmd.load      = 1'b1;
                                task_cnt_next = task_cnt_reg + srts_pkg::CNT_W'(1);
                                if (task_burst == '0)
                                begin
                                    fin_cnt_next = fin_cnt_reg + srts_pkg::CNT_W'(1);
                                end
                            end
                            else
                            begin
                                res_rej_next = 1'b1;
                            end
                        end
                        srts_pkg::OP_TICK:
                        begin
                            if (fin_cnt_reg < task_cnt_reg)
                            begin
                                scan_start = 1'b1;
                                state_next = S_SCAN;
                            end
                        end
                        default:
                        begin
                            state_next = S_POST;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (best_valid)
                begin
                    state_next = S_APPLY;
                end
            end
            S_APPLY:
            begin
                // Time advances, saturating at TIME_MAX, on every working tick; the winner, if any, loses one unit.
                clock_next = clock_inc;
                if (best.found)
                begin
                    cmd.run      = 1'b1;
                    res_ran_next = 1'b1;
                    res_pid_next = srts_pkg::PID_W'(best.idx) + srts_pkg::PID_W'(1);
                    if (best.rem == srts_pkg::FIELD_W'(1))
                    begin
                        res_fin_next = 1'b1;
                        fin_cnt_next = fin_cnt_reg + srts_pkg::CNT_W'(1);
                        res_tat_next = clock_inc - srts_pkg::TIME_W'(best.arr);
                        res_bur_next = best.bur;
                    end
                end
                state_next = S_POST;
            end
            S_POST:
            begin
                // Hand the result over once the output register is free.
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_ran_next   = res_ran_reg;
                    out_pid_next   = res_pid_reg;
                    out_fin_next   = res_fin_reg;
                    out_tat_next   = res_tat_reg;
                    out_wt_next    = (res_tat_reg >= bur_wide) ? res_tat_reg - bur_wide : '0;
                    out_done_next  = (fin_cnt_reg >= task_cnt_reg);
                    out_now_next   = clock_reg;
                    out_rej_next   = res_rej_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            task_cnt_reg  <= '0;
            fin_cnt_reg   <= '0;
            clock_reg     <= '0;
            res_ran_reg   <= 1'b0;
            res_pid_reg   <= '0;
            res_fin_reg   <= 1'b0;
            res_tat_reg   <= '0;
            res_bur_reg   <= '0;
            res_rej_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            out_ran_reg   <= 1'b0;
            out_pid_reg   <= '0;
            out_fin_reg   <= 1'b0;
            out_tat_reg   <= '0;
            out_wt_reg    <= '0;
            out_done_reg  <= 1'b0;
            out_now_reg   <= '0;
            out_rej_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            task_cnt_reg  <= task_cnt_next;
            fin_cnt_reg   <= fin_cnt_next;
            clock_reg     <= clock_next;
            res_ran_reg   <= res_ran_next;
            res_pid_reg   <= res_pid_next;
            res_fin_reg   <= res_fin_next;
            res_tat_reg   <= res_tat_next;
            res_bur_reg   <= res_bur_next;
            res_rej_reg   <= res_rej_next;
            out_valid_reg <= out_valid_next;
            out_ran_reg   <= out_ran_next;
            out_pid_reg   <= out_pid_next;
            out_fin_reg   <= out_fin_next;
            out_tat_reg   <= out_tat_next;
            out_wt_reg    <= out_wt_next;
            out_done_reg  <= out_done_next;
            out_now_reg   <= out_now_next;
            out_rej_reg   <= out_rej_next;
        end
    end

    assign result_valid  = out_valid_reg;
    assign ran           = out_ran_reg;
    assign process_id    = out_pid_reg;
    assign finished      = out_fin_reg;
    assign turnaround    = out_tat_reg;
    assign waiting       = out_wt_reg;
    assign all_done      = out_done_reg;
    assign now_time      = out_now_reg;
    assign load_rejected = out_rej_reg;

endmodule

// ----- hw/rtl/srts_checker.sv -----
// Port-level checks on the scheduler's result beats, bound to the top level.
// Depends on srts_pkg and shortest_remaining_time_scheduler.
module srts_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          result_valid,
    input  logic                          result_ready,
    input  logic                          ran,
    input  logic [srts_pkg::PID_W-1:0]    process_id,
    input  logic                          finished,
    input  logic [srts_pkg::TIME_W-1:0]   turnaround,
    input  logic [srts_pkg::TIME_W-1:0]   waiting,
    input  logic                          load_rejected
);

    // A result beat stays offered until it is taken.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("result beat dropped before it was taken");

    // A beat without a run names no task and finishes nothing.
    a_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !ran |-> (process_id == '0) && !finished)
        else $error("task reported on a beat where nothing ran");

    // A task that ran has a task number from one upward and is not flagged as a rejected load.
    a_pid: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && ran |-> (process_id != '0) && !load_rejected)
        else $error("run reported without a valid task number");

    // On a finished beat, waiting never exceeds turnaround.
    a_wait: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && finished |-> waiting <= turnaround)
        else $error("waiting time exceeds turnaround");

endmodule

bind shortest_remaining_time_scheduler srts_checker u_srts_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .ran           (ran),
    .process_id    (process_id),
    .finished      (finished),
    .turnaround    (turnaround),
    .waiting       (waiting),
    .load_rejected (load_rejected)
);

// ----- test/shortest_remaining_time_scheduler_tb.sv -----
// Self-checking testbench for the shortest-remaining-time scheduler.
// Depends on srts_pkg and shortest_remaining_time_scheduler; it predicts every result beat
// from its own copy of the task table and compares each beat field by field.
module shortest_remaining_time_scheduler_tb;

    // One expected result beat.
    typedef struct packed {
        logic                        ran;
        logic [srts_pkg::PID_W-1:0]  pid;
        logic                        finished;
        logic [srts_pkg::TIME_W-1:0] turnaround;
        logic [srts_pkg::TIME_W-1:0] waiting;
        logic                        all_done;
        logic [srts_pkg::TIME_W-1:0] now_time;
        logic                        rejected;
    } outcome_t;

    localparam int STALL_LIMIT = 4000;

    logic                         clk;
    logic                         rst_n;
    logic                         item_valid;
    logic                         item_ready;
    logic [1:0]                   operation;
    logic [srts_pkg::FIELD_W-1:0] task_arrival;
    logic [srts_pkg::FIELD_W-1:0] task_burst;
    logic                         result_valid;
    logic                         result_ready;
    logic                         ran;
    logic [srts_pkg::PID_W-1:0]   process_id;
    logic                         finished;
    logic [srts_pkg::TIME_W-1:0]  turnaround;
    logic [srts_pkg::TIME_W-1:0]  waiting;
    logic                         all_done;
    logic [srts_pkg::TIME_W-1:0]  now_time;
    logic                         load_rejected;

    // Shadow copy of the scheduler state.
    logic [srts_pkg::FIELD_W-1:0] shadow_arrival [srts_pkg::MAX_TASKS];
    logic [srts_pkg::FIELD_W-1:0] shadow_burst [srts_pkg::MAX_TASKS];
    logic [srts_pkg::FIELD_W-1:0] shadow_remaining [srts_pkg::MAX_TASKS];
    logic                         shadow_done [srts_pkg::MAX_TASKS];
    int                           shadow_tasks;
    int                           shadow_finished;
    logic [srts_pkg::TIME_W-1:0]  shadow_clock;

    outcome_t            pending_outcomes [$];
    int                  error_count;
    int                  items_sent;
    int                  quiet_cycles;
    bit                  no_idle;

    shortest_remaining_time_scheduler uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_ready    (item_ready),
        .operation     (operation),
        .task_arrival  (task_arrival),
        .task_burst    (task_burst),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .ran           (ran),
        .process_id    (process_id),
        .finished      (finished),
        .turnaround    (turnaround),
        .waiting       (waiting),
        .all_done      (all_done),
        .now_time      (now_time),
        .load_rejected (load_rejected)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Work out the result of one item and update the shadow state.
    function automatic outcome_t predict_outcome(input srts_pkg::op_t op,
                                                 input logic [srts_pkg::FIELD_W-1:0] arr,
                                                 input logic [srts_pkg::FIELD_W-1:0] bur);
        outcome_t o;
        int best;
        logic [srts_pkg::TIME_W-1:0] span;
        o = '0;
        best = -1;
        case (op)
            srts_pkg::OP_CLEAR:
            begin
                shadow_tasks = 0;
                shadow_finished = 0;
                shadow_clock = '0;
            end
            srts_pkg::OP_LOAD:
            begin
                if (shadow_tasks >= srts_pkg::MAX_TASKS)
                    o.rejected = 1'b1;
                else
                begin
                    shadow_arrival[shadow_tasks] = arr;
                    shadow_burst[shadow_tasks] = bur;
                    shadow_remaining[shadow_tasks] = bur;
                    // A zero-length task counts as finished at once and never runs.
                    shadow_done[shadow_tasks] = (bur == '0);
                    if (bur == '0)
                        shadow_finished++;
                    shadow_tasks++;
                end
            end
            srts_pkg::OP_TICK:
            begin
                if (shadow_finished < shadow_tasks)
                begin
                    for (int i = 0; i < shadow_tasks; i++)
                    begin
                        if (!shadow_done[i] &&
                            srts_pkg::TIME_W'(shadow_arrival[i]) <= shadow_clock &&
                            (best < 0 || shadow_remaining[i] < shadow_remaining[best]))
                            best = i;
                    end
                    if (shadow_clock != srts_pkg::TIME_MAX)
                        shadow_clock++;
                    if (best >= 0)
                    begin
                        o.ran = 1'b1;
                        o.pid = srts_pkg::PID_W'(best + 1);
                        shadow_remaining[best] = shadow_remaining[best] - 1'b1;
                        if (shadow_remaining[best] == '0)
                        begin
                            shadow_done[best] = 1'b1;
                            shadow_finished++;
                            o.finished = 1'b1;
                            span = shadow_clock - srts_pkg::TIME_W'(shadow_arrival[best]);
                            o.turnaround = span;
                            o.waiting = (span >= srts_pkg::TIME_W'(shadow_burst[best])) ?
                                        span - srts_pkg::TIME_W'(shadow_burst[best]) : '0;
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
        o.all_done = (shadow_finished >= shadow_tasks);
        o.now_time = shadow_clock;
        return o;
    endfunction

    function automatic void check_field(input string name,
                                        input logic [srts_pkg::TIME_W-1:0] want,
                                        input logic [srts_pkg::TIME_W-1:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            error_count++;
        end
    endfunction

    // Present one item after a random gap and record its expected result on acceptance.
    task automatic send_item(input srts_pkg::op_t op, input logic [srts_pkg::FIELD_W-1:0] arr,
                             input logic [srts_pkg::FIELD_W-1:0] bur);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        if (gap != 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        operation    <= op;
        task_arrival <= arr;
        task_burst   <= bur;
        item_valid   <= 1'b1;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        pending_outcomes.push_back(predict_outcome(op, arr, bur));
        items_sent++;
    endtask

    // Ticks carry random don't-care fields so those bits toggle too.
    task automatic send_ticks(input int count);
        repeat (count)
            send_item(srts_pkg::OP_TICK, srts_pkg::FIELD_W'($urandom),
                      srts_pkg::FIELD_W'($urandom));
    endtask

    // Hold the sender off until every outstanding result beat has been taken.
    task automatic wait_for_outcomes();
        item_valid <= 1'b0;
        @(posedge clk);
        while (pending_outcomes.size() != 0)
            @(posedge clk);
    endtask

    // Ticks and unused codes on an empty table leave time at zero.
    task automatic test_empty_table();
        send_ticks(1);
        send_item(srts_pkg::OP_NONE, 16'hFFFF, 16'hFFFF);
        send_item(srts_pkg::OP_CLEAR, 16'h0000, 16'h0000);
    endtask

    // Field extremes, a zero-length task and a task that never arrives.
    task automatic test_field_extremes();
        send_item(srts_pkg::OP_CLEAR, 16'hFFFF, 16'hFFFF);
        send_item(srts_pkg::OP_LOAD, 16'h0000, 16'h0001);
        send_ticks(1);
        send_item(srts_pkg::OP_LOAD, 16'hFFFF, 16'hFFFF);
        send_ticks(1);
        send_item(srts_pkg::OP_LOAD, 16'h0003, 16'h0000);
        send_item(srts_pkg::OP_NONE, 16'h0000, 16'h0000);
        send_item(srts_pkg::OP_CLEAR, 16'h0000, 16'h0000);
    endtask

    // A long task is preempted by two shorter equal ones; the lower index wins the tie.
    task automatic test_preemption_and_ties();
        send_item(srts_pkg::OP_LOAD, 16'd0, 16'd3);
        send_item(srts_pkg::OP_LOAD, 16'd1, 16'd1);
        send_item(srts_pkg::OP_LOAD, 16'd1, 16'd1);
        send_ticks(6);
    endtask

    // Fill the table past capacity, then run every task to completion.
    task automatic test_table_full();
        send_item(srts_pkg::OP_CLEAR, srts_pkg::FIELD_W'($urandom),
                  srts_pkg::FIELD_W'($urandom));
        repeat (srts_pkg::MAX_TASKS + 2)
            send_item(srts_pkg::OP_LOAD, srts_pkg::FIELD_W'($urandom_range(0, 3)),
                      srts_pkg::FIELD_W'($urandom_range(1, 3)));
        send_ticks(3 * srts_pkg::MAX_TASKS + 6);
        wait_for_outcomes();
    endtask

    // Random sessions: usually a clear, a few loads, then mostly ticks with some noise mixed in.
    task automatic test_random_sessions(input int target);
        int n;
        int ticks;
        int pick;
        logic [srts_pkg::FIELD_W-1:0] arr;
        logic [srts_pkg::FIELD_W-1:0] bur;
        while (items_sent < target)
        begin
            no_idle = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 9) != 0)
                send_item(srts_pkg::OP_CLEAR, srts_pkg::FIELD_W'($urandom),
                          srts_pkg::FIELD_W'($urandom));
            n = $urandom_range(1, 6);
            ticks = 16;
            for (int k = 0; k < n; k++)
            begin
                arr = ($urandom_range(0, 7) == 0) ? srts_pkg::FIELD_W'($urandom) :
                      srts_pkg::FIELD_W'($urandom_range(0, 15));
                bur = ($urandom_range(0, 7) == 0) ? srts_pkg::FIELD_W'($urandom) :
                      srts_pkg::FIELD_W'($urandom_range(1, 10));
                send_item(srts_pkg::OP_LOAD, arr, bur);
                ticks += (bur > 10) ? 10 : int'(bur);
            end
            if (ticks > 60)
                ticks = 60;
            for (int k = 0; k < ticks; k++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 88)
                    send_ticks(1);
                else if (pick < 94)
                    send_item(srts_pkg::OP_LOAD, srts_pkg::FIELD_W'($urandom),
                              srts_pkg::FIELD_W'($urandom));
                else if (pick < 98)
                    send_item(srts_pkg::OP_NONE, srts_pkg::FIELD_W'($urandom),
                              srts_pkg::FIELD_W'($urandom));
                else
                    send_item(srts_pkg::OP_CLEAR, srts_pkg::FIELD_W'($urandom),
                              srts_pkg::FIELD_W'($urandom));
            end
            if ($urandom_range(0, 3) == 0)
                wait_for_outcomes();
        end
        no_idle = 1'b0;
    endtask

    // Result side: a random stall per beat, counted from when the beat shows up.
    initial
    begin : drain_results
        int stall;
        result_ready <= 1'b0;
        forever
        begin
            stall = no_idle ? 0 : $urandom_range(0, 4);
            if (stall != 0)
            begin
                result_ready <= 1'b0;
                @(posedge clk);
                while (!result_valid)
                    @(posedge clk);
                repeat (stall - 1) @(posedge clk);
            end
            result_ready <= 1'b1;
            @(posedge clk);
            while (!result_valid)
                @(posedge clk);
        end
    end

    // Compare each accepted result beat with the oldest expectation.
    always @(posedge clk)
    begin : check_results
        outcome_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_outcomes.size() == 0)
            begin
                $display("%0t: result beat with no expected result, actual pid %0d now %0d",
                         $time, process_id, now_time);
                error_count++;
            end
            else
            begin
                want = pending_outcomes.pop_front();
                check_field("ran", want.ran, ran);
                check_field("process_id", want.pid, process_id);
                check_field("finished", want.finished, finished);
                check_field("turnaround", want.turnaround, turnaround);
                check_field("waiting", want.waiting, waiting);
                check_field("all_done", want.all_done, all_done);
                check_field("now_time", want.now_time, now_time);
                check_field("load_rejected", want.rejected, load_rejected);
            end
        end
    end

    // Watchdog: too many cycles without a beat on either channel ends the run.
    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && item_ready) || (result_valid && result_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
            $display("FAILURE");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        items_sent   = 0;
        no_idle      = 1'b0;
        shadow_tasks = 0;
        shadow_finished = 0;
        shadow_clock = '0;
        rst_n        <= 1'b0;
        item_valid   <= 1'b0;
        operation    <= srts_pkg::OP_CLEAR;
        task_arrival <= '0;
        task_burst   <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        test_empty_table();
        test_field_extremes();
        test_preemption_and_ties();
        test_table_full();
        test_random_sessions(850);

        // Let the last results come back, then allow for one full tick of latency.
        item_valid <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(posedge clk);
        repeat (srts_pkg::MAX_TASKS + 8) @(posedge clk);
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/srts_pkg.sv
hw/rtl/srts_cell.sv
hw/rtl/srts_chain.sv
hw/rtl/shortest_remaining_time_scheduler.sv
hw/rtl/srts_checker.sv
test/shortest_remaining_time_scheduler_tb.sv
